// ===== rtl/vwd_pkg.sv =====
// vwd_pkg: shared types, constants and hash helpers for the vertex weld table
// used by every module of the block but vwd_ram; depends on nothing
`timescale 1ns / 1ps
package vwd_pkg;

  localparam int MAX_VERTS  = 4096;
  localparam int HASH_SLOTS = 8192;
  localparam int IDX_W      = $clog2(MAX_VERTS);
  localparam int CNT_W      = $clog2(MAX_VERTS + 1);
  localparam int SLOT_W     = $clog2(HASH_SLOTS);
  localparam int PRB_W      = $clog2(HASH_SLOTS + 1);
  localparam int NWORDS     = 10;
  localparam int WI_W       = $clog2(NWORDS);
  localparam int KEY_W      = 32 * NWORDS;

  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;
  localparam logic [31:0] FIN_MUL   = 32'h7FEB352D;

  typedef enum logic [1:0] {
    REG_KEY_NORMALS = 2'd0,
    REG_HAS_UV      = 2'd1,
    REG_HAS_SKIN    = 2'd2,
    REG_NONE        = 2'd3
  } reg_e;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] nrm_x;
    logic [31:0] nrm_y;
    logic [31:0] nrm_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] skin_joints;
    logic [31:0] skin_weights;
    logic        last_vertex;
  } in_t;

  typedef struct packed {
    logic [11:0] welded_index;
    logic        is_new;
    logic        overflow;
  } out_t;

  typedef struct packed {
    logic key_normals;
    logic has_uv;
    logic has_skin;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    cfg_t              cfg;
    logic              last;
    logic [SLOT_W-1:0] slot;
  } job_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             take;
  } stat_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MIX, F_FIN1, F_FIN2, F_PUSH
  } front_e;

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_RD, B_SLOT, B_KEY, B_CLR, B_CLR_WR
  } back_e;

  function automatic logic [KEY_W-1:0] pack_key(in_t d);
    pack_key = {d.skin_weights, d.skin_joints, d.tex_v, d.tex_u,
                d.nrm_z, d.nrm_y, d.nrm_x, d.pos_z, d.pos_y, d.pos_x};
  endfunction

  function automatic logic word_en(cfg_t c, logic [WI_W-1:0] wi);
    logic en;
    case (wi)
      4'd3, 4'd4, 4'd5: en = c.key_normals;
      4'd6, 4'd7:       en = c.has_uv;
      4'd8, 4'd9:       en = c.has_skin;
      default:          en = 1'b1;
    endcase
    word_en = en;
  endfunction

  function automatic logic key_match(cfg_t c, logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    logic m;
    m = (a[95:0] == b[95:0]);
    if (c.key_normals && (a[191:96] != b[191:96])) m = 1'b0;
    if (c.has_uv && (a[255:192] != b[255:192])) m = 1'b0;
    if (c.has_skin && (a[319:256] != b[319:256])) m = 1'b0;
    key_match = m;
  endfunction

endpackage

// ===== rtl/vwd_ram.sv =====
// vwd_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module vwd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vwd_front.sv =====
// vwd_front: accepts corners, builds the weld key and its fnv-1a slot hash
// depends on vwd_pkg
`timescale 1ns / 1ps
module vwd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vwd_pkg::in_t  data_i,
  input  logic          push,
  output logic          full,
  input  vwd_pkg::cfg_t cfg_i,
  output vwd_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);
  import vwd_pkg::*;

  front_e           state_q, state_d;
  logic [KEY_W-1:0] key_q, key_d;
  cfg_t             cfg_q, cfg_d;
  logic             last_q, last_d;
  logic [31:0]      h_q, h_d;
  logic [WI_W-1:0]  wi_q, wi_d;
  logic [31:0]      word;
  logic [31:0]      h_fin;

  assign word  = key_q[wi_q*32 +: 32];
  assign h_fin = h_q ^ (h_q >> 15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    cfg_q  <= cfg_d;
    last_q <= last_d;
    h_q    <= h_d;
    wi_q   <= wi_d;
  end

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    cfg_d       = cfg_q;
    last_d      = last_q;
    h_d         = h_q;
    wi_d        = wi_q;
    full        = 1'b1;
    job_valid_o = 1'b0;
    job_o.key   = key_q;
    job_o.cfg   = cfg_q;
    job_o.last  = last_q;
    job_o.slot  = h_fin[SLOT_W-1:0];
    unique case (state_q)
      F_IDLE: begin
        full = 1'b0;
        if (push) begin
          key_d   = pack_key(data_i);
          cfg_d   = cfg_i;
          last_d  = data_i.last_vertex;
          h_d     = FNV_BASIS;
          wi_d    = '0;
          state_d = F_MIX;
        end
      end
      F_MIX: begin
        if (word_en(cfg_q, wi_q)) begin
          h_d = 32'((h_q ^ word) * FNV_PRIME);
        end
        if (wi_q == WI_W'(NWORDS - 1)) begin
          state_d = F_FIN1;
        end else begin
          wi_d = wi_q + 1'b1;
        end
      end
      F_FIN1: begin
        h_d     = h_q ^ (h_q >> 16);
        state_d = F_FIN2;
      end
      F_FIN2: begin
        h_d     = 32'(h_q * FIN_MUL);
        state_d = F_PUSH;
      end
      F_PUSH: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

endmodule

// ===== rtl/vwd_fifo.sv =====
// vwd_fifo: two entry queue of hashed jobs between front and back
// depends on vwd_pkg
`timescale 1ns / 1ps
module vwd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vwd_pkg::job_t wr_i,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  output vwd_pkg::job_t rd_o,
  output logic          rd_valid_o,
  input  logic          rd_take_i
);
  import vwd_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_o       = mem_q[rp_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_take_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wp_q <= ~wp_q;
      if (do_rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_i;
    end
  end

endmodule

// ===== rtl/vwd_back.sv =====
// vwd_back: linear probe of the slot table, key compare, insert and mesh clear
// depends on vwd_pkg and vwd_ram
`timescale 1ns / 1ps
module vwd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vwd_pkg::job_t  job_i,
  input  logic           job_valid_i,
  output logic           job_take_o,
  output vwd_pkg::out_t  result_o,
  output logic           empty,
  input  logic           pop,
  output vwd_pkg::stat_t stat_o
);
  import vwd_pkg::*;

  back_e             state_q, state_d;
  job_t              job_q, job_d;
  logic [SLOT_W-1:0] probe_q, probe_d;
  logic [PRB_W-1:0]  prb_q, prb_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]  sweep_q, sweep_d;
  logic [CNT_W-1:0]  ent_q, ent_d;
  out_t              out_q, out_d;
  logic              ov_q, ov_d;

  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr, slot_raddr;
  logic [CNT_W-1:0]  slot_wdata, slot_rdata;
  logic              key_we;
  logic [IDX_W-1:0]  key_waddr, key_raddr;
  logic [KEY_W-1:0]  key_rdata;
  logic              log_we;
  logic [SLOT_W-1:0] log_rdata;
  logic [CNT_W-1:0]  ent_m1;

  assign ent_m1 = slot_rdata - 1'b1;

  vwd_ram #(.W(CNT_W), .D(HASH_SLOTS)) u_slot_ram (
    .clk_i, .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(slot_wdata),
    .raddr_i(slot_raddr), .rdata_o(slot_rdata)
  );

  vwd_ram #(.W(KEY_W), .D(MAX_VERTS)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(job_q.key),
    .raddr_i(key_raddr), .rdata_o(key_rdata)
  );

  vwd_ram #(.W(SLOT_W), .D(MAX_VERTS)) u_log_ram (
    .clk_i, .we_i(log_we), .waddr_i(key_waddr), .wdata_i(probe_q),
    .raddr_i(sweep_q[IDX_W-1:0]), .rdata_o(log_rdata)
  );

  assign result_o     = out_q;
  assign empty        = !ov_q;
  assign stat_o.count = count_q;
  assign stat_o.take  = job_take_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_INIT;
      count_q <= '0;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    probe_q <= probe_d;
    prb_q   <= prb_d;
    sweep_q <= sweep_d;
    ent_q   <= ent_d;
    out_q   <= out_d;
  end

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    probe_d    = probe_q;
    prb_d      = prb_q;
    count_d    = count_q;
    clr_d      = clr_q;
    sweep_d    = sweep_q;
    ent_d      = ent_q;
    out_d      = out_q;
    ov_d       = ov_q && !pop;
    job_take_o = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = probe_q;
    slot_wdata = '0;
    slot_raddr = probe_q;
    key_we     = 1'b0;
    key_waddr  = count_q[IDX_W-1:0];
    key_raddr  = ent_m1[IDX_W-1:0];
    log_we     = 1'b0;
    unique case (state_q)
      B_INIT: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == SLOT_W'(HASH_SLOTS - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (job_valid_i && !ov_q) begin
          job_take_o = 1'b1;
          job_d      = job_i;
          probe_d    = job_i.slot;
          prb_d      = '0;
          state_d    = B_RD;
        end
      end
      B_RD: state_d = B_SLOT;
      B_SLOT: begin
        if (slot_rdata == '0) begin
          if (count_q < CNT_W'(MAX_VERTS)) begin
            key_we     = 1'b1;
            log_we     = 1'b1;
            slot_we    = 1'b1;
            slot_wdata = count_q + 1'b1;
            count_d    = count_q + 1'b1;
            out_d      = '{welded_index: 12'(count_q), is_new: 1'b1, overflow: 1'b0};
          end else begin
            out_d = '{welded_index: 12'd0, is_new: 1'b0, overflow: 1'b1};
          end
          ov_d    = 1'b1;
          sweep_d = '0;
          state_d = job_q.last ? B_CLR : B_IDLE;
        end else begin
          ent_d   = ent_m1;
          state_d = B_KEY;
        end
      end
      B_KEY: begin
        if (key_match(job_q.cfg, key_rdata, job_q.key)) begin
          out_d   = '{welded_index: 12'(ent_q), is_new: 1'b0, overflow: 1'b0};
          ov_d    = 1'b1;
          sweep_d = '0;
          state_d = job_q.last ? B_CLR : B_IDLE;
        end else if (prb_q == PRB_W'(HASH_SLOTS - 1)) begin
          out_d   = '{welded_index: 12'd0, is_new: 1'b0, overflow: 1'b1};
          ov_d    = 1'b1;
          sweep_d = '0;
          state_d = job_q.last ? B_CLR : B_IDLE;
        end else begin
          probe_d = probe_q + 1'b1;
          prb_d   = prb_q + 1'b1;
          state_d = B_RD;
        end
      end
      B_CLR: begin
        if (sweep_q == count_q) begin
          count_d = '0;
          state_d = B_IDLE;
        end else begin
          state_d = B_CLR_WR;
        end
      end
      B_CLR_WR: begin
        slot_we    = 1'b1;
        slot_waddr = log_rdata;
        sweep_d    = sweep_q + 1'b1;
        state_d    = B_CLR;
      end
      default: state_d = B_IDLE;
    endcase
  end

endmodule

// ===== rtl/vertex_weld_dedup_table_unit.sv =====
// vertex_weld_dedup_table_unit: top level, config registers, front, queue, back
// depends on vwd_pkg, vwd_front, vwd_fifo, vwd_back
`timescale 1ns / 1ps
// Corner input: drive data_i and raise push; a transaction happens on a clock
// edge with push high and full low. Results come out as a queue: while empty is
// low result_o holds the oldest result, taken on an edge with pop high.
// Each corner yields one result: the welded index, is_new for a fresh vertex,
// or overflow when no entry is left.
// The front hashes a corner by stepping through every key word, with one fnv multiply
// per keyed word, then the finish, and takes no new corner until its job enters the
// queue. The back probes the slot table, each probe in steps (slot read, stored key
// read, compare); an empty slot ends the probe after the slot read with an insert. A
// two entry queue lets front and back overlap.
// After a corner with last_vertex, the back clears the slots used by the mesh,
// one welded vertex at a time (log read, then slot write), before taking the next corner.
// After reset the slot table is cleared, one slot a cycle, while the front still
// accepts up to three corners; config writes work at any time.
// A stalled receiver holds the back after one result; the queue then fills and
// full rises. Registers: key_normals at 0x0, has_uv at 0x4, has_skin at 0x8.
module vertex_weld_dedup_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vwd_pkg::in_t  data_i,
  input  logic          push,
  output logic          full,
  output vwd_pkg::out_t result_o,
  output logic          empty,
  input  logic          pop,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import vwd_pkg::*;

  cfg_t  cfg_q, cfg_d;
  reg_e  reg_sel;
  job_t  f_job, q_job;
  logic  f_valid, f_ready, q_valid, q_take;
  stat_t stat;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{key_normals: 1'b0, has_uv: 1'b1, has_skin: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    unique case (reg_sel)
      REG_KEY_NORMALS: prdata[0] = cfg_q.key_normals;
      REG_HAS_UV:      prdata[0] = cfg_q.has_uv;
      REG_HAS_SKIN:    prdata[0] = cfg_q.has_skin;
      default:         prdata    = '0;
    endcase
    if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_KEY_NORMALS: cfg_d.key_normals = pwdata[0];
        REG_HAS_UV:      cfg_d.has_uv      = pwdata[0];
        REG_HAS_SKIN:    cfg_d.has_skin    = pwdata[0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  vwd_front u_front (
    .clk_i, .rst_ni, .data_i, .push, .full, .cfg_i(cfg_q),
    .job_o(f_job), .job_valid_o(f_valid), .job_ready_i(f_ready)
  );

  vwd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(f_job), .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .rd_o(q_job), .rd_valid_o(q_valid), .rd_take_i(q_take)
  );

  vwd_back u_back (
    .clk_i, .rst_ni, .job_i(q_job), .job_valid_i(q_valid), .job_take_o(q_take),
    .result_o, .empty, .pop, .stat_o(stat)
  );

  a_new_xor_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(result_o.is_new && result_o.overflow))
    else $error("result flags both new and overflow");

  a_ovf_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.overflow) |-> (result_o.welded_index == 12'd0))
    else $error("overflow result carries an index");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= CNT_W'(MAX_VERTS))
    else $error("welded vertex count beyond capacity");

  a_take_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.take |-> (empty && q_valid))
    else $error("back took a job while a result waits");

endmodule

// ===== dv/vertex_weld_dedup_table_unit_test.sv =====
// vertex_weld_dedup_table_unit_test: self-checking bench for the vertex weld table,
// predicting welded indices with a hash table model; depends on vwd_pkg and the rtl
`timescale 1ns / 1ps
module vertex_weld_dedup_table_unit_test;
  import vwd_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  in_t         corner_d;
  logic        push_d;
  logic        full_w;
  out_t        weld_w;
  logic        empty_w;
  logic        pop_d;
  logic        psel_d;
  logic        penable_d;
  logic        pwrite_d;
  logic [3:0]  paddr_d;
  logic [31:0] pwdata_d;
  logic [31:0] prdata_w;
  logic        pready_w;

  vertex_weld_dedup_table_unit u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .data_i   (corner_d),
    .push     (push_d),
    .full     (full_w),
    .result_o (weld_w),
    .empty    (empty_w),
    .pop      (pop_d),
    .psel     (psel_d),
    .penable  (penable_d),
    .pwrite   (pwrite_d),
    .paddr    (paddr_d),
    .pwdata   (pwdata_d),
    .prdata   (prdata_w),
    .pready   (pready_w)
  );

  // weld table model
  logic [31:0] vtx_words [MAX_VERTS][NWORDS];
  logic [12:0] slot_tab [HASH_SLOTS];
  int          vtx_count;
  cfg_t        weld_cfg;

  in_t  corner_q [$];
  out_t weld_q [$];
  int   mismatch_cnt;
  int   idle_cycles;
  bit   hold_pop;

  function automatic void add_corner(input in_t c);
    corner_q.insert(corner_q.size(), c);
  endfunction

  function automatic bit word_keyed(int w);
    if (w >= 3 && w <= 5) return weld_cfg.key_normals;
    if (w == 6 || w == 7) return weld_cfg.has_uv;
    if (w == 8 || w == 9) return weld_cfg.has_skin;
    return 1'b1;
  endfunction

  function automatic out_t weld_corner(in_t c);
    logic [31:0] w [NWORDS];
    logic [31:0] h;
    int          slot;
    int          free_slot;
    bit          hit;
    bit          have_free;
    bit          same;
    int          v;
    out_t        r;
    w = '{c.pos_x, c.pos_y, c.pos_z, c.nrm_x, c.nrm_y, c.nrm_z,
          c.tex_u, c.tex_v, c.skin_joints, c.skin_weights};
    h = 32'h811C9DC5;
    for (int i = 0; i < NWORDS; i++)
      if (word_keyed(i)) h = (h ^ w[i]) * 32'h01000193;
    h = h ^ (h >> 16);
    h = h * 32'h7FEB352D;
    h = h ^ (h >> 15);
    slot = int'(h % HASH_SLOTS);
    hit = 0;
    have_free = 0;
    free_slot = 0;
    v = 0;
    for (int p = 0; p < HASH_SLOTS; p++) begin
      if (slot_tab[slot] == 0) begin
        have_free = 1;
        free_slot = slot;
        break;
      end
      v = int'(slot_tab[slot]) - 1;
      same = 1;
      for (int i = 0; i < NWORDS; i++)
        if (word_keyed(i) && vtx_words[v][i] != w[i]) same = 0;
      if (same) begin
        hit = 1;
        break;
      end
      slot = (slot + 1) % HASH_SLOTS;
    end
    r = '0;
    if (hit) r.welded_index = v[11:0];
    else if (have_free && vtx_count < MAX_VERTS) begin
      for (int i = 0; i < NWORDS; i++) vtx_words[vtx_count][i] = w[i];
      slot_tab[free_slot] = 13'(vtx_count + 1);
      r.welded_index = vtx_count[11:0];
      r.is_new = 1;
      vtx_count++;
    end else r.overflow = 1;
    if (c.last_vertex) begin
      for (int s = 0; s < HASH_SLOTS; s++) slot_tab[s] = 0;
      vtx_count = 0;
    end
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver: bursts and gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (push_d && !full_w) begin
      weld_q.insert(weld_q.size(), weld_corner(corner_d));
      void'(corner_q.pop_front());
    end
    if (!rst_n) begin
      push_d <= 0;
    end else if (push_d && full_w) begin
      push_d <= 1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      push_d <= 0;
    end else if (corner_q.size() > (push_d && !full_w ? 0 : 0)) begin
      push_d <= 1;
      corner_d <= corner_q[0];
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      end else burst_left <= burst_left - 1;
    end else push_d <= 0;
  end

  // monitor and receiver stalls
  int stall_phase;
  always @(posedge clk) begin
    if (pop_d && !empty_w) begin
      idle_cycles <= 0;
      if (weld_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected transaction: %p", weld_w);
      end else begin
        if (weld_w.welded_index !== weld_q[0].welded_index ||
            weld_w.is_new !== weld_q[0].is_new ||
            weld_w.overflow !== weld_q[0].overflow) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected idx %0d new %0b ovf %0b, got idx %0d new %0b ovf %0b",
                     weld_q[0].welded_index, weld_q[0].is_new, weld_q[0].overflow,
                     weld_w.welded_index, weld_w.is_new, weld_w.overflow);
        end
        void'(weld_q.pop_front());
      end
    end else if (push_d && !full_w) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    stall_phase <= stall_phase + 1;
    if (!rst_n || hold_pop) pop_d <= 0;
    else if (stall_phase[8]) pop_d <= 1;
    else pop_d <= (stall_phase[2:0] != 3'd5) && ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic reg_write(input reg_e idx, input logic v);
    @(posedge clk);
    psel_d <= 1;
    penable_d <= 0;
    pwrite_d <= 1;
    paddr_d <= {idx, 2'b00};
    pwdata_d <= {31'($urandom()), v};
    @(posedge clk);
    penable_d <= 1;
    @(posedge clk);
    psel_d <= 0;
    penable_d <= 0;
    pwrite_d <= 0;
    case (idx)
      REG_KEY_NORMALS: weld_cfg.key_normals = v;
      REG_HAS_UV:      weld_cfg.has_uv = v;
      REG_HAS_SKIN:    weld_cfg.has_skin = v;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (corner_q.size() != 0 || weld_q.size() != 0 || push_d) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_t rand_corner();
    in_t c;
    c.pos_x = rand_word();
    c.pos_y = rand_word();
    c.pos_z = rand_word();
    c.nrm_x = rand_word();
    c.nrm_y = rand_word();
    c.nrm_z = rand_word();
    c.tex_u = rand_word();
    c.tex_v = rand_word();
    c.skin_joints = $urandom();
    c.skin_weights = $urandom();
    c.last_vertex = 0;
    return c;
  endfunction

  // one mesh: a pool of corners reused with some variation in nrm_x, tex_u and skin_weights
  task automatic queue_mesh(input int n, input int pool_n);
    in_t pool [$];
    in_t c;
    for (int i = 0; i < pool_n; i++) pool.insert(pool.size(), rand_corner());
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) c = rand_corner();
      else begin
        c = pool[$urandom_range(0, pool_n - 1)];
        if ($urandom_range(0, 3) == 0) c.nrm_x = $urandom();
        if ($urandom_range(0, 3) == 0) c.skin_weights = $urandom();
        if ($urandom_range(0, 5) == 0) c.tex_u = $urandom();
      end
      c.last_vertex = (i == n - 1);
      add_corner(c);
    end
  endtask

  in_t d;
  initial begin
    rst_n = 0;
    push_d = 0;
    pop_d = 0;
    corner_d = '0;
    psel_d = 0;
    penable_d = 0;
    pwrite_d = 0;
    paddr_d = '0;
    pwdata_d = '0;
    mismatch_cnt = 0;
    idle_cycles = 0;
    hold_pop = 0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    vtx_count = 0;
    weld_cfg = '{key_normals: 1'b0, has_uv: 1'b1, has_skin: 1'b0};
    for (int s = 0; s < HASH_SLOTS; s++) slot_tab[s] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    repeat (9000) @(posedge clk);

    // directed: zero signs, all ones, repeats and end of mesh
    d = '0;
    add_corner(d);
    add_corner(d);
    d.pos_x = 32'h8000_0000;
    add_corner(d);
    d = '1;
    d.last_vertex = 0;
    add_corner(d);
    d.nrm_y = 32'h0;
    add_corner(d);
    d.tex_v = 32'h0;
    add_corner(d);
    d.skin_joints = 32'h0;
    add_corner(d);
    d.last_vertex = 1;
    add_corner(d);
    add_corner(d);
    drain();

    reg_write(REG_KEY_NORMALS, 1);
    reg_write(REG_HAS_UV, 0);
    reg_write(REG_HAS_SKIN, 1);
    reg_write(REG_NONE, 1);
    d = '0;
    add_corner(d);
    d.nrm_z = 32'h8000_0000;
    add_corner(d);
    d.tex_u = 32'h1;
    add_corner(d);
    d.skin_weights = 32'hFFFF_FFFF;
    d.last_vertex = 1;
    add_corner(d);
    drain();

    // long receiver hold while the sender keeps offering
    hold_pop = 1;
    queue_mesh(40, 10);
    repeat (1500) @(posedge clk);
    hold_pop = 0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_KEY_NORMALS, ph[0]);
      reg_write(REG_HAS_UV, ph[1]);
      reg_write(REG_HAS_SKIN, ph[2]);
      for (int m = 0; m < 4; m++) queue_mesh($urandom_range(10, 60), $urandom_range(1, 20));
      drain();
    end

    // a long mesh of distinct positions, then one corner twice, the second ending the mesh
    reg_write(REG_KEY_NORMALS, 0);
    reg_write(REG_HAS_UV, 0);
    reg_write(REG_HAS_SKIN, 0);
    for (int i = 0; i < 180; i++) begin
      d = '0;
      d.pos_x = 32'(i);
      d.pos_y = $urandom();
      add_corner(d);
    end
    d = '0;
    d.pos_x = 5;
    add_corner(d);
    d.last_vertex = 1;
    add_corner(d);
    drain();

    if (mismatch_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/vwd_pkg.sv
rtl/vwd_ram.sv
rtl/vwd_front.sv
rtl/vwd_fifo.sv
rtl/vwd_back.sv
rtl/vertex_weld_dedup_table_unit.sv
dv/vertex_weld_dedup_table_unit_test.sv
